// ===== rtl/core/rth_pkg.sv =====
// Package for the RGB to HSV converter: channel width, pixel and result word types.
// No dependencies; used by rgb_to_hsv_converter.
package rth_pkg;

  localparam int CHANNEL_BITS = 16;
  localparam int THRESH_BITS  = 16;
  localparam logic [THRESH_BITS-1:0] GREY_THRESHOLD_RESET = THRESH_BITS'(6);

  typedef logic [CHANNEL_BITS-1:0] chan_t;
  typedef logic [THRESH_BITS-1:0]  thresh_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    chan_t alpha_in;
  } rgba_t;

  typedef struct packed {
    chan_t hue;
    chan_t saturation;
    chan_t brightness;
    chan_t alpha_out;
  } hsv_t;

endpackage

// ===== rtl/core/rgb_to_hsv_converter.sv =====
// RGB(A) to HSV(A) converter, fully pipelined, one pixel word per clock.
// Depends on rth_pkg (types and channel width).
//
//   channel   ports                      direction  notes
//   pixel     start, busy, pixel         in         taken when start & !busy
//   result    done, result               out        one-cycle strobe, no backpressure
//   config    cfg_we, cfg_wdata          in         grey threshold, no read-back
//
// The pipe takes one word per clock.
// Five front stages (capture, max/min, delta, scaling, hue numerator), then two
// restoring dividers of one quotient bit per stage running side by side, then
// the output register. busy is always low: the pipe never stalls.
// Synchronous reset clears the valid bits and sets the grey threshold to 6.
module rgb_to_hsv_converter (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  rth_pkg::rgba_t  pixel,
  output logic            done,
  output rth_pkg::hsv_t   result,
  input  logic            cfg_we,
  input  rth_pkg::thresh_t cfg_wdata
);
  import rth_pkg::*;

  localparam int N    = CHANNEL_BITS;
  localparam int HW   = N + 3;                // width of 6*delta and the hue numerator
  localparam int CMPW = (N > THRESH_BITS) ? N : THRESH_BITS;
  localparam int LAT  = N + 6;

  typedef enum logic [1:0] {OFS_0, OFS_2, OFS_4, OFS_6} ofs_t;

  typedef struct packed {
    logic  grey;
    chan_t mx;
    chan_t alpha;
  } side_t;

  thresh_t grey_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      grey_threshold <= GREY_THRESHOLD_RESET;
    end else if (cfg_we) begin
      grey_threshold <= cfg_wdata;
    end
  end

  assign busy = 1'b0;

  // ---- P1: capture
  logic  p1_v;
  rgba_t p1_px;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
    end else begin
      p1_v <= start & ~busy;
    end
    p1_px <= pixel;
  end

  // ---- P2: max, min, sector offset and signed difference
  chan_t             c_mx, c_mn;
  ofs_t              c_ofs;
  logic signed [N:0] c_diff;
  logic signed [N:0] d_gb, d_br, d_rg;

  always_comb begin
    d_gb = $signed({1'b0, p1_px.green}) - $signed({1'b0, p1_px.blue});
    d_br = $signed({1'b0, p1_px.blue})  - $signed({1'b0, p1_px.red});
    d_rg = $signed({1'b0, p1_px.red})   - $signed({1'b0, p1_px.green});
    c_mx = p1_px.red;
    c_mn = p1_px.red;
    if (p1_px.green > c_mx) c_mx = p1_px.green;
    if (p1_px.blue  > c_mx) c_mx = p1_px.blue;
    if (p1_px.green < c_mn) c_mn = p1_px.green;
    if (p1_px.blue  < c_mn) c_mn = p1_px.blue;
    // red wins ties, then green
    if (p1_px.red >= p1_px.green && p1_px.red >= p1_px.blue) begin
      c_ofs  = (p1_px.green >= p1_px.blue) ? OFS_0 : OFS_6;
      c_diff = d_gb;
    end else if (p1_px.green >= p1_px.blue) begin
      c_ofs  = OFS_2;
      c_diff = d_br;
    end else begin
      c_ofs  = OFS_4;
      c_diff = d_rg;
    end
  end

  logic              p2_v;
  chan_t             p2_mx, p2_mn, p2_alpha;
  ofs_t              p2_ofs;
  logic signed [N:0] p2_diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_v <= 1'b0;
    end else begin
      p2_v <= p1_v;
    end
    p2_mx    <= c_mx;
    p2_mn    <= c_mn;
    p2_alpha <= p1_px.alpha_in;
    p2_ofs   <= c_ofs;
    p2_diff  <= c_diff;
  end

  // ---- P3: delta
  logic              p3_v;
  chan_t             p3_mx, p3_delta, p3_alpha;
  ofs_t              p3_ofs;
  logic signed [N:0] p3_diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_v <= 1'b0;
    end else begin
      p3_v <= p2_v;
    end
    p3_mx    <= p2_mx;
    p3_delta <= p2_mx - p2_mn;
    p3_alpha <= p2_alpha;
    p3_ofs   <= p2_ofs;
    p3_diff  <= p2_diff;
  end

  // ---- P4: grey test, 6*delta, offset*delta, delta*(2^N-1)
  logic [HW-1:0]  c_d2, c_d4, c_kd;
  logic [2*N-1:0] c_satx;

  always_comb begin
    c_d2 = {2'b00, p3_delta, 1'b0};
    c_d4 = {1'b0, p3_delta, 2'b00};
    case (p3_ofs)
      OFS_0:   c_kd = '0;
      OFS_2:   c_kd = c_d2;
      OFS_4:   c_kd = c_d4;
      OFS_6:   c_kd = c_d4 + c_d2;
      default: c_kd = '0;
    endcase
    c_satx = {p3_delta, {N{1'b0}}} - {{N{1'b0}}, p3_delta};
  end

  logic              p4_v, p4_grey;
  chan_t             p4_mx, p4_alpha;
  logic [HW-1:0]     p4_den, p4_kd;
  logic [2*N-1:0]    p4_satx;
  logic signed [N:0] p4_diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      p4_v <= 1'b0;
    end else begin
      p4_v <= p3_v;
    end
    p4_grey  <= CMPW'(p3_delta) <= CMPW'(grey_threshold);
    p4_mx    <= p3_mx;
    p4_alpha <= p3_alpha;
    p4_den   <= c_d4 + c_d2;
    p4_kd    <= c_kd;
    p4_satx  <= c_satx;
    p4_diff  <= p3_diff;
  end

  // ---- P5: hue numerator, in [0, 6*delta) for non-grey words
  logic signed [HW:0] c_hsum;

  assign c_hsum = $signed({1'b0, p4_kd}) + $signed({{3{p4_diff[N]}}, p4_diff});

  logic          dv    [0:N];
  side_t         dside [0:N];
  chan_t         s_rem [0:N];
  chan_t         s_lq  [0:N];
  chan_t         s_den [0:N];
  logic [HW-1:0] h_rem [0:N];
  chan_t         h_q   [0:N];
  logic [HW-1:0] h_den [0:N];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else begin
      dv[0] <= p4_v;
    end
    dside[0] <= '{grey: p4_grey, mx: p4_mx, alpha: p4_alpha};
    s_rem[0] <= p4_satx[2*N-1:N];
    s_lq[0]  <= p4_satx[N-1:0];
    s_den[0] <= p4_mx;
    h_rem[0] <= c_hsum[HW-1:0];
    h_q[0]   <= '0;
    h_den[0] <= p4_den;
  end

  // ---- divider stages: one quotient bit of each division per stage
  for (genvar i = 0; i < N; i++) begin : g_div
    logic [N:0]  s_trial, s_sub;
    logic [HW:0] h_trial, h_sub;
    logic        s_ge, h_ge;

    assign s_trial = {s_rem[i], s_lq[i][N-1]};
    assign s_sub   = s_trial - {1'b0, s_den[i]};
    assign s_ge    = s_trial >= {1'b0, s_den[i]};
    assign h_trial = {h_rem[i], 1'b0};
    assign h_sub   = h_trial - {1'b0, h_den[i]};
    assign h_ge    = h_trial >= {1'b0, h_den[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[i+1] <= 1'b0;
      end else begin
        dv[i+1] <= dv[i];
      end
      dside[i+1] <= dside[i];
      s_rem[i+1] <= s_ge ? s_sub[N-1:0] : s_trial[N-1:0];
      s_lq[i+1]  <= {s_lq[i][N-2:0], s_ge};
      s_den[i+1] <= s_den[i];
      h_rem[i+1] <= h_ge ? h_sub[HW-1:0] : h_trial[HW-1:0];
      h_q[i+1]   <= {h_q[i][N-2:0], h_ge};
      h_den[i+1] <= h_den[i];
    end
  end

  // ---- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv[N];
    end
    result.hue        <= dside[N].grey ? '0 : h_q[N];
    result.saturation <= dside[N].grey ? '0 : s_lq[N];
    result.brightness <= dside[N].mx;
    result.alpha_out  <= dside[N].alpha;
  end

  // ---- checks
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result word without a matching accepted pixel");

  a_alpha: assert property (@(posedge clk) disable iff (rst)
    done |-> result.alpha_out == $past(pixel.alpha_in, LAT))
    else $error("alpha not carried through the pipe");

  // zero saturation only happens on grey words, which also zero the hue
  a_grey: assert property (@(posedge clk) disable iff (rst)
    (done && result.saturation == '0) |-> result.hue == '0)
    else $error("zero saturation with nonzero hue");

  a_black: assert property (@(posedge clk) disable iff (rst)
    (done && result.brightness == '0) |-> result.saturation == '0)
    else $error("black pixel with nonzero saturation");

endmodule
